### hw/rtl/lsac_pkg.sv
// Shared types, constants and codes for the set-associative LRU cache model.
`default_nettype none

package lsac_pkg;

  // Geometry of the line store.
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int AGE_W        = 16;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);

  localparam int ADDR_W  = 64;
  localparam int TOTAL_W = 32;

  // Access kinds.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS        = 2'd2;

  localparam int CFG_DATA_W = 6;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [AGE_W-1:0]  age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic hit;    // valid line with a matching tag
    logic empty;  // line not valid
    logic older;  // aged line is at least as old as the best so far
  } way_res_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]         hits;
    logic               missed;
    logic               evicted;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/lsac_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lsac_way_unit.sv
// Per-way lookup unit: tag compare, age update and replacement candidate test.
`default_nettype none

module lsac_way_unit (
  input  wire  lsac_pkg::line_t                  line,
  input  wire  logic [lsac_pkg::ADDR_W-1:0]      tag,
  input  wire  logic [lsac_pkg::AGE_W-1:0]       best_age,
  output lsac_pkg::line_t                        line_next,
  output lsac_pkg::way_res_t                     res
);

  logic [lsac_pkg::AGE_W-1:0] age_inc;

  // Ages stop at the all-ones value.
  assign age_inc = (line.age == {lsac_pkg::AGE_W{1'b1}}) ? line.age
                                                          : line.age + 1'b1;

  always_comb begin
    line_next = line;
    res       = '0;
    if (!line.valid) begin
      res.empty = 1'b1;
    end else if (line.tag == tag) begin
      line_next.age = '0;
      res.hit       = 1'b1;
    end else begin
      line_next.age = age_inc;
      res.older     = (age_inc >= best_age);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lru_set_assoc_cache_sim.sv
// Top level of the set-associative cache model with age-counter LRU replacement.
//
//  Channel | Signals                          | Direction | Moves
//  --------+----------------------------------+-----------+------------------------------
//  req     | req_valid, req_ready, req        | in        | one access item (kind, address)
//  rsp     | rsp_valid, rsp_ready, rsp        | out       | one result item per access
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | one register write
//          | cfg_data                         |           |
//
// After acceptance an access runs through two shift steps, the row load, a scan of the
// ways in use, a finish step and the result write; ready comes back after that. One
// shared lookup unit visits one way of the set per cycle, and a modify scans the set
// twice, with a finish step after each scan.
// The set row lives in a 64-entry RAM; per-row valid flops that reset clears make an
// unwritten row read as empty, so no clearing pass follows reset.
// A finished result waits in the output register; the block stalls before writing a new
// result only while that register is still full.

`default_nettype none

module lru_set_assoc_cache_sim (
  input  wire  logic                                  clk,
  input  wire  logic                                  rst,
  input  wire  logic                                  req_valid,
  output logic                                        req_ready,
  input  wire  lsac_pkg::req_t                        req,
  output logic                                        rsp_valid,
  input  wire  logic                                  rsp_ready,
  output lsac_pkg::rsp_t                              rsp,
  input  wire  logic                                  cfg_valid,
  output logic                                        cfg_ready,
  input  wire  logic [1:0]                            cfg_index,
  input  wire  logic [lsac_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Sequencer states. The address is split by two passes through one shifter,
  // the set row is read, then each way is visited once per lookup pass.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_B,
    ST_SHIFT_S,
    ST_LOAD,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [2:0] set_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_cfg;

  // Item registers.
  logic [1:0]                      kind;
  logic [lsac_pkg::ADDR_W-1:0]     addr;
  logic [lsac_pkg::ADDR_W-1:0]     work_addr;
  logic [lsac_pkg::ADDR_W-1:0]     tag;
  logic [lsac_pkg::SET_W-1:0]      set;
  lsac_pkg::row_t                  work_row;

  // Scan bookkeeping.
  logic [lsac_pkg::WAY_W-1:0]      way;
  logic                            hit_flag;
  logic                            empty_found;
  logic [lsac_pkg::WAY_W-1:0]      empty_way;
  logic [lsac_pkg::WAY_W-1:0]      best_way;
  logic [lsac_pkg::AGE_W-1:0]      best_age;
  logic                            pass;

  // Per-item result and running totals.
  logic [1:0]                      hits;
  logic                            missed;
  logic                            evicted;
  logic [lsac_pkg::TOTAL_W-1:0]    hit_total;
  logic [lsac_pkg::TOTAL_W-1:0]    miss_total;
  logic [lsac_pkg::TOTAL_W-1:0]    eviction_total;

  logic [lsac_pkg::NUM_SETS-1:0]   row_valid;

  // Effective configuration after clamping out-of-range values.
  logic [2:0]                      set_eff;
  logic [lsac_pkg::WCNT_W-1:0]     ways_eff;
  logic [6:0]                      split_sum;

  always_comb begin
    if (32'(set_bits) > 32'(lsac_pkg::MAX_SET_BITS)) begin
      set_eff = 3'(lsac_pkg::MAX_SET_BITS);
    end else begin
      set_eff = set_bits;
    end
    if (ways_cfg == 4'd0) begin
      ways_eff = lsac_pkg::WCNT_W'(1);
    end else if (32'(ways_cfg) > 32'(lsac_pkg::MAX_WAYS)) begin
      ways_eff = lsac_pkg::WCNT_W'(lsac_pkg::MAX_WAYS);
    end else begin
      ways_eff = lsac_pkg::WCNT_W'(ways_cfg);
    end
  end

  assign split_sum = 7'(offset_bits) + 7'(set_eff);

  // The one shifter serves both steps of the address split: first the block
  // offset is dropped, then the set index, which leaves the tag.
  logic [lsac_pkg::ADDR_W-1:0] sh_in;
  logic [5:0]                  sh_amt;
  logic [lsac_pkg::ADDR_W-1:0] sh_out;

  assign sh_in  = (state == ST_SHIFT_B) ? addr : work_addr;
  assign sh_amt = (state == ST_SHIFT_B) ? offset_bits : 6'(set_eff);
  assign sh_out = sh_in >> sh_amt;

  // The set index is the low bits left after the offset, masked to the
  // configured width and to the number of sets present.
  logic [lsac_pkg::SET_W-1:0] set_mask;
  logic [lsac_pkg::SET_W-1:0] set_next;

  assign set_mask = lsac_pkg::SET_W'((32'd1 << set_eff) - 32'd1)
                    & lsac_pkg::SET_W'(lsac_pkg::NUM_SETS - 1);
  assign set_next = work_addr[lsac_pkg::SET_W-1:0] & set_mask;

  // Line store: one row per set, all ways of the set side by side.
  lsac_pkg::row_t ram_rdata;
  logic           ram_we;

  lsac_ram #(
    .WIDTH($bits(lsac_pkg::row_t)),
    .DEPTH(lsac_pkg::NUM_SETS)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(set),
    .wdata(work_row),
    .re   (state == ST_SHIFT_S),
    .raddr(set_next),
    .rdata(ram_rdata)
  );

  // Shared lookup unit, applied to the way under the scan pointer.
  lsac_pkg::line_t    way_line_next;
  lsac_pkg::way_res_t way_res;

  lsac_way_unit u_way (
    .line     (work_row[way]),
    .tag      (tag),
    .best_age (best_age),
    .line_next(way_line_next),
    .res      (way_res)
  );

  logic last_way;
  assign last_way = ((lsac_pkg::WCNT_W'(way) + lsac_pkg::WCNT_W'(1)) == ways_eff);

  // The result register is free when empty or being emptied this cycle.
  logic rsp_free;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign ram_we    = (state == ST_DONE) && rsp_free;
  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  function automatic logic [lsac_pkg::TOTAL_W-1:0] sat_inc(
    input logic [lsac_pkg::TOTAL_W-1:0] v
  );
    return (v == {lsac_pkg::TOTAL_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  logic [lsac_pkg::WAY_W-1:0] fill_way;
  assign fill_way = empty_found ? empty_way : best_way;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      set_bits       <= 3'd0;
      offset_bits    <= 6'd0;
      ways_cfg       <= 4'd1;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
      row_valid      <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsac_pkg::CFG_SET_BITS:    set_bits    <= cfg_data[2:0];
          lsac_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data[5:0];
          lsac_pkg::CFG_WAYS:        ways_cfg    <= cfg_data[3:0];
          default: ;
        endcase
      end

      // When a new result is loaded in the same cycle, the register stays full.
      if (rsp_valid && rsp_ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            kind    <= req.kind;
            addr    <= req.address;
            hits    <= 2'd0;
            missed  <= 1'b0;
            evicted <= 1'b0;
            pass    <= 1'b0;
            state   <= ST_SHIFT_B;
          end
        end
        ST_SHIFT_B: begin
          work_addr <= sh_out;
          state     <= ST_SHIFT_S;
        end
        ST_SHIFT_S: begin
          // Once offset and index cover the whole address, no tag bits remain.
          tag   <= split_sum[6] ? '0 : sh_out;
          set   <= set_next;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          // A row never written since reset holds no valid lines.
          work_row    <= row_valid[set] ? ram_rdata : '0;
          way         <= '0;
          hit_flag    <= 1'b0;
          empty_found <= 1'b0;
          best_way    <= '0;
          best_age    <= '0;
          state       <= ST_SCAN;
        end
        ST_SCAN: begin
          work_row[way] <= way_line_next;
          if (way_res.hit) begin
            hit_flag <= 1'b1;
          end
          if (way_res.empty) begin
            empty_found <= 1'b1;
            empty_way   <= way;
          end
          if (way_res.older) begin
            best_way <= way;
            best_age <= way_line_next.age;
          end
          if (last_way) begin
            state <= ST_FINISH;
          end else begin
            way <= way + 1'b1;
          end
        end
        ST_FINISH: begin
          if (hit_flag) begin
            hits      <= hits + 2'd1;
            hit_total <= sat_inc(hit_total);
          end else begin
            // Fill the highest empty way, or else replace the oldest line.
            work_row[fill_way] <= '{valid: 1'b1, tag: tag, age: '0};
            miss_total         <= sat_inc(miss_total);
            if (!pass) begin
              missed <= 1'b1;
            end
            if (!empty_found) begin
              evicted        <= 1'b1;
              eviction_total <= sat_inc(eviction_total);
            end
          end
          if (!pass && kind == lsac_pkg::KIND_MODIFY) begin
            // A modify looks the same line up a second time.
            pass        <= 1'b1;
            way         <= '0;
            hit_flag    <= 1'b0;
            empty_found <= 1'b0;
            best_way    <= '0;
            best_age    <= '0;
            state       <= ST_SCAN;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            row_valid[set]      <= 1'b1;
            rsp_valid           <= 1'b1;
            rsp.hits            <= hits;
            rsp.missed          <= missed;
            rsp.evicted         <= evicted;
            rsp.total_hits      <= hit_total;
            rsp.total_misses    <= miss_total;
            rsp.total_evictions <= eviction_total;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted access always starts the address split on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_SHIFT_B)
    else $error("accepted access did not start the address split");

  // Only the first lookup can miss, so a miss allows at most one hit.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.missed && rsp.hits == 2'd2) && rsp.hits != 2'd3)
    else $error("hit count inconsistent with miss flag");

  // A replacement only ever follows a miss.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted |-> rsp.missed)
    else $error("eviction reported without a miss");

  // The scan pointer never leaves the ways in use.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> 32'(way) < 32'(ways_eff))
    else $error("way scan ran past the ways in use");

endmodule

`default_nettype wire
